/* sv/drpm_pkg.sv */
// Shared types and constants for the device region page mapper.
`default_nettype none

package drpm_pkg;

    // Field widths on the stream ports
    localparam int ADDR_W      = 52;
    localparam int SLOTS_OUT_W = 9;
    localparam int STORE_W     = 31;
    localparam int S_TDATA_W   = 104;
    localparam int M_TDATA_W   = 64;

    // Fixed windows of the 32-bit virtual space
    localparam logic [63:0] WINDOW_START = 64'h0000_0000_8000_0000;
    localparam logic [63:0] REGION_START = 64'h0000_0000_C000_0000;
    localparam logic [63:0] SPACE_END    = 64'h0000_0000_FFFF_FFFF;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CALC   = 6'b000010,
        ST_CHECK  = 6'b000100,
        ST_SCAN   = 6'b001000,
        ST_APPEND = 6'b010000,
        ST_DONE   = 6'b100000
    } drpm_state_t;

endpackage

`default_nettype wire

/* sv/drpm_page_alu.sv */
// Shared page-number incrementer, limit compare and slot counter step.
`default_nettype none

module drpm_page_alu #(
    parameter int PHYS_W = 43,
    parameter int CNT_W  = 9
) (
    input  wire logic [PHYS_W-1:0] phys_i,
    input  wire logic [PHYS_W-1:0] limit_i,
    input  wire logic [CNT_W-1:0]  cnt_i,
    output logic      [PHYS_W-1:0] phys_inc_o,
    output logic                   phys_le_o,
    output logic      [CNT_W-1:0]  cnt_inc_o
);

    // Advance the page number and the slot count, test against the last page
    assign phys_inc_o = phys_i + PHYS_W'(1);
    assign phys_le_o  = (phys_i <= limit_i);
    assign cnt_inc_o  = cnt_i + CNT_W'(1);

endmodule

`default_nettype wire

/* sv/device_region_page_mapper.sv */
// Top level of the device region page mapper: sequencer, slot table and stream ports.
// Throughput: one request at a time; s_tready is high only while idle, and the
// table walk runs through one shared page/slot step unit at one slot per cycle.
// Reset (aresetn low, synchronous) clears the sequencer and the slot count to zero;
// table contents are not cleared and are only compared below the slot count.
`default_nettype none

module device_region_page_mapper #(
    parameter int MAX_SLOTS = 256,
    parameter int PAGE_BITS = 21
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // s_tdata: phys_base [51:0], region_bytes [103:52]
    input  wire logic [drpm_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: startup_only [0]
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // m_tdata: mapped_addr [51:0], slots_in_use [60:52], zero pad [63:61]
    output logic      [drpm_pkg::M_TDATA_W-1:0]  m_tdata,
    // m_tuser: ok [0]
    output logic                                 m_tuser
);

    localparam int SLOT_CW = $clog2(MAX_SLOTS + 1);
    localparam int SLOT_IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int PHYS_W  = 64 - PAGE_BITS;
    localparam logic [63:0] REGION_END =
        drpm_pkg::REGION_START + (64'(MAX_SLOTS) << PAGE_BITS) - 64'd1;
    localparam logic [63:0] PAGE_MASK = (64'd1 << PAGE_BITS) - 64'd1;
    localparam int PAD_W = drpm_pkg::M_TDATA_W - drpm_pkg::ADDR_W - drpm_pkg::SLOTS_OUT_W;

    // Control registers
    drpm_pkg::drpm_state_t state_reg, state_next;
    logic [SLOT_CW-1:0] slots_used_reg, slots_used_next;
    logic               pend_reg, pend_next;

    // Payload registers
    logic [drpm_pkg::ADDR_W-1:0] base_reg, base_next;
    logic [drpm_pkg::ADDR_W-1:0] len_reg, len_next;
    logic                        startup_reg, startup_next;
    logic [63:0]                 last_reg, last_next;
    logic [PHYS_W-1:0]           first_phys_reg, first_phys_next;
    logic [PHYS_W-1:0]           last_phys_reg, last_phys_next;
    logic [PHYS_W-1:0]           cur_phys_reg, cur_phys_next;
    logic [SLOT_CW-1:0]          cur_slot_reg, cur_slot_next;
    logic [SLOT_CW-1:0]          first_slot_reg, first_slot_next;
    logic [drpm_pkg::ADDR_W-1:0] out_addr_reg, out_addr_next;
    logic                        out_ok_reg, out_ok_next;
    logic [drpm_pkg::SLOTS_OUT_W-1:0] out_used_reg, out_used_next;

    // Slot table
    logic [drpm_pkg::STORE_W-1:0] slot_mem [MAX_SLOTS];
    logic [drpm_pkg::STORE_W-1:0] rd_data_reg;
    logic [SLOT_IW-1:0]           rd_addr;
    logic                         mem_we;

    // Shared step unit
    logic [SLOT_CW-1:0] alu_cnt;
    logic [SLOT_CW-1:0] alu_cnt_inc;
    logic [PHYS_W-1:0]  alu_phys_inc;
    logic               alu_le;

    logic [63:0] base_ext;
    logic [63:0] low_limit;
    logic [63:0] success_addr;
    logic        bypass;
    logic        scan_more;
    logic        slot_match;

    drpm_page_alu #(
        .PHYS_W (PHYS_W),
        .CNT_W  (SLOT_CW)
    ) u_alu (
        .phys_i     (cur_phys_reg),
        .limit_i    (last_phys_reg),
        .cnt_i      (alu_cnt),
        .phys_inc_o (alu_phys_inc),
        .phys_le_o  (alu_le),
        .cnt_inc_o  (alu_cnt_inc)
    );

    // Decode the region and the scan condition
    always_comb begin
        base_ext     = 64'(base_reg);
        low_limit    = startup_reg ? drpm_pkg::REGION_START : drpm_pkg::WINDOW_START;
        bypass       = (last_reg < low_limit)
                    || ((base_ext > REGION_END) && (last_reg <= drpm_pkg::SPACE_END));
        alu_cnt      = (state_reg == drpm_pkg::ST_APPEND) ? slots_used_reg : cur_slot_reg;
        scan_more    = (cur_slot_reg < slots_used_reg) && alu_le;
        slot_match   = ({{(PHYS_W - drpm_pkg::STORE_W){1'b0}}, rd_data_reg} == cur_phys_reg);
        rd_addr      = pend_reg ? alu_cnt_inc[SLOT_IW-1:0] : cur_slot_reg[SLOT_IW-1:0];
        success_addr = drpm_pkg::REGION_START + (64'(first_slot_reg) << PAGE_BITS)
                     + (base_ext & PAGE_MASK);
    end

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        slots_used_next = slots_used_reg;
        pend_next       = pend_reg;
        base_next       = base_reg;
        len_next        = len_reg;
        startup_next    = startup_reg;
        last_next       = last_reg;
        first_phys_next = first_phys_reg;
        last_phys_next  = last_phys_reg;
        cur_phys_next   = cur_phys_reg;
        cur_slot_next   = cur_slot_reg;
        first_slot_next = first_slot_reg;
        out_addr_next   = out_addr_reg;
        out_ok_next     = out_ok_reg;
        out_used_next   = out_used_reg;
        mem_we          = 1'b0;
        case (state_reg)
            drpm_pkg::ST_IDLE: begin
                // Capture the request
                if (s_tvalid) begin
                    base_next    = s_tdata[drpm_pkg::ADDR_W-1:0];
                    len_next     = s_tdata[2*drpm_pkg::ADDR_W-1:drpm_pkg::ADDR_W];
                    startup_next = s_tuser;
                    state_next   = drpm_pkg::ST_CALC;
                end
            end
            drpm_pkg::ST_CALC: begin
                // Form the last byte address with 64-bit wrap
                last_next  = base_ext + 64'(len_reg) - 64'd1;
                state_next = drpm_pkg::ST_CHECK;
            end
            drpm_pkg::ST_CHECK: begin
                first_phys_next = base_ext[63:PAGE_BITS];
                last_phys_next  = last_reg[63:PAGE_BITS];
                cur_phys_next   = base_ext[63:PAGE_BITS];
                cur_slot_next   = '0;
                first_slot_next = '0;
                pend_next       = 1'b0;
                if (bypass) begin
                    out_addr_next = base_reg;
                    out_ok_next   = 1'b1;
                    out_used_next = drpm_pkg::SLOTS_OUT_W'(slots_used_reg);
                    state_next    = drpm_pkg::ST_DONE;
                end else begin
                    state_next = drpm_pkg::ST_SCAN;
                end
            end
            drpm_pkg::ST_SCAN: begin
                // Walk the table one slot per cycle, read one slot ahead
                if (!scan_more) begin
                    pend_next  = 1'b0;
                    state_next = drpm_pkg::ST_APPEND;
                end else if (!pend_reg) begin
                    pend_next = 1'b1;
                end else begin
                    cur_slot_next = alu_cnt_inc;
                    if (slot_match) begin
                        cur_phys_next = alu_phys_inc;
                    end else begin
                        first_slot_next = alu_cnt_inc;
                        cur_phys_next   = first_phys_reg;
                    end
                end
            end
            drpm_pkg::ST_APPEND: begin
                // Append missing pages until done or the table is full
                if (!alu_le) begin
                    out_addr_next = success_addr[drpm_pkg::ADDR_W-1:0];
                    out_ok_next   = 1'b1;
                    out_used_next = drpm_pkg::SLOTS_OUT_W'(slots_used_reg);
                    state_next    = drpm_pkg::ST_DONE;
                end else if (slots_used_reg >= SLOT_CW'(MAX_SLOTS)) begin
                    out_addr_next = '0;
                    out_ok_next   = 1'b0;
                    out_used_next = drpm_pkg::SLOTS_OUT_W'(slots_used_reg);
                    state_next    = drpm_pkg::ST_DONE;
                end else begin
                    mem_we          = 1'b1;
                    slots_used_next = alu_cnt_inc;
                    cur_phys_next   = alu_phys_inc;
                end
            end
            drpm_pkg::ST_DONE: begin
                // Hold the result until taken
                if (m_tready) begin
                    state_next = drpm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = drpm_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= drpm_pkg::ST_IDLE;
            slots_used_reg <= '0;
            pend_reg       <= 1'b0;
        end else begin
            state_reg      <= state_next;
            slots_used_reg <= slots_used_next;
            pend_reg       <= pend_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        base_reg       <= base_next;
        len_reg        <= len_next;
        startup_reg    <= startup_next;
        last_reg       <= last_next;
        first_phys_reg <= first_phys_next;
        last_phys_reg  <= last_phys_next;
        cur_phys_reg   <= cur_phys_next;
        cur_slot_reg   <= cur_slot_next;
        first_slot_reg <= first_slot_next;
        out_addr_reg   <= out_addr_next;
        out_ok_reg     <= out_ok_next;
        out_used_reg   <= out_used_next;
    end

    // Table write port and registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[slots_used_reg[SLOT_IW-1:0]] <= cur_phys_reg[drpm_pkg::STORE_W-1:0];
        end
        rd_data_reg <= slot_mem[rd_addr];
    end

    // Stream ports
    assign s_tready = (state_reg == drpm_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == drpm_pkg::ST_DONE);
    assign m_tdata  = {{PAD_W{1'b0}}, out_used_reg, out_addr_reg};
    assign m_tuser  = out_ok_reg;

endmodule

`default_nettype wire

/* sv/drpm_checker.sv */
// Port-level checks for the device region page mapper, bound to the top level.
`default_nettype none

module drpm_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [drpm_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire logic                            m_tuser
);

    // Ready returns in the cycle after reset
    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("s_tready low after reset");

    // An accepted request closes the input until its result is taken
    a_accept_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("s_tready high right after a request was accepted");

    // No new request is taken while a result is pending
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("s_tready high while a result is pending");

    // A failed mapping reports address zero
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[drpm_pkg::ADDR_W-1:0] == '0))
        else $error("failed mapping with nonzero address");

    // A stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

endmodule

bind device_region_page_mapper drpm_checker u_drpm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

/* bench/device_region_page_mapper_tb.sv */
// Self-checking testbench for the device region page mapper: directed rows, random requests.
`timescale 1ns / 1ps

module device_region_page_mapper_tb;

    localparam int SLOT_COUNT   = 256;
    localparam int PAGE_LOG2    = 21;
    localparam int RANDOM_ITEMS = 1000;
    localparam int LATE_ITEMS   = 200;
    localparam int DRAIN_CYCLES = 2 * SLOT_COUNT + 8;
    localparam int STALL_LIMIT  = 5000;
    localparam int SPAN_KEEP    = 64;
    localparam logic [63:0] DEVICE_AREA_END =
        drpm_pkg::REGION_START + (64'(SLOT_COUNT) << PAGE_LOG2) - 64'd1;

    typedef struct packed {
        logic [drpm_pkg::ADDR_W-1:0]      addr;
        logic                             ok;
        logic [drpm_pkg::SLOTS_OUT_W-1:0] slots;
    } map_result_t;

    typedef struct packed {
        logic [drpm_pkg::ADDR_W-1:0] base;
        logic [drpm_pkg::ADDR_W-1:0] len;
        logic                        startup;
        logic                        typed;
        map_result_t                 want;
    } plan_row_t;

    typedef struct packed {
        logic [drpm_pkg::ADDR_W-1:0] base;
        logic [drpm_pkg::ADDR_W-1:0] len;
    } span_t;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [drpm_pkg::S_TDATA_W-1:0] s_tdata;
    logic                           s_tuser;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [drpm_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tuser;

    // Shadow copy of the slot table
    logic [drpm_pkg::STORE_W-1:0] shadow_page [SLOT_COUNT];
    int                           shadow_used = 0;

    map_result_t awaited_maps [$];
    plan_row_t   plan [$];
    span_t       mapped_spans [$];
    bit          steady = 1'b0;
    int          mismatches = 0;

    always #10 aclk = ~aclk;

    device_region_page_mapper #(
        .MAX_SLOTS(SLOT_COUNT),
        .PAGE_BITS(PAGE_LOG2)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // Work out the mapping of one request and advance the shadow table
    function automatic map_result_t predict_mapping(logic [drpm_pkg::ADDR_W-1:0] base,
                                                    logic [drpm_pkg::ADDR_W-1:0] len,
                                                    logic startup);
        map_result_t res;
        logic [63:0] last;
        logic [63:0] low_limit;
        logic [63:0] first_pg;
        logic [63:0] last_pg;
        logic [63:0] want_pg;
        int          slot;
        int          run_start;
        last      = 64'(base) + 64'(len) - 64'd1;
        low_limit = startup ? drpm_pkg::REGION_START : drpm_pkg::WINDOW_START;
        // Pass through low regions and regions above the device area
        if (last < low_limit
            || (64'(base) > DEVICE_AREA_END && last <= drpm_pkg::SPACE_END)) begin
            res.addr  = base;
            res.ok    = 1'b1;
            res.slots = drpm_pkg::SLOTS_OUT_W'(shadow_used);
            return res;
        end
        first_pg  = 64'(base) >> PAGE_LOG2;
        last_pg   = last >> PAGE_LOG2;
        want_pg   = first_pg;
        slot      = 0;
        run_start = 0;
        // Scan for a run; a mismatching slot is not retried as a start
        while (slot < shadow_used && want_pg <= last_pg) begin
            if ({33'b0, shadow_page[slot]} == want_pg) begin
                want_pg++;
            end else begin
                run_start = slot + 1;
                want_pg   = first_pg;
            end
            slot++;
        end
        // Append missing pages; pages already appended stay on overflow
        while (want_pg <= last_pg) begin
            if (shadow_used >= SLOT_COUNT) begin
                res.addr  = '0;
                res.ok    = 1'b0;
                res.slots = drpm_pkg::SLOTS_OUT_W'(shadow_used);
                return res;
            end
            shadow_page[shadow_used] = want_pg[drpm_pkg::STORE_W-1:0];
            shadow_used++;
            want_pg++;
        end
        res.addr  = drpm_pkg::ADDR_W'(drpm_pkg::REGION_START + (64'(run_start) << PAGE_LOG2)
                                      + 64'(base[PAGE_LOG2-1:0]));
        res.ok    = 1'b1;
        res.slots = drpm_pkg::SLOTS_OUT_W'(shadow_used);
        return res;
    endfunction

    function automatic logic [drpm_pkg::ADDR_W-1:0] random_addr();
        return drpm_pkg::ADDR_W'({$urandom, $urandom});
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        $display("%0t: %s mismatch, expected %h, actual %h", $realtime, what, want, got);
    endtask

    task automatic add_row(input logic [drpm_pkg::ADDR_W-1:0] base,
                           input logic [drpm_pkg::ADDR_W-1:0] len,
                           input logic startup, input logic typed,
                           input logic [drpm_pkg::ADDR_W-1:0] w_addr, input logic w_ok,
                           input logic [drpm_pkg::SLOTS_OUT_W-1:0] w_slots);
        plan_row_t row;
        row.base       = base;
        row.len        = len;
        row.startup    = startup;
        row.typed      = typed;
        row.want.addr  = w_addr;
        row.want.ok    = w_ok;
        row.want.slots = w_slots;
        plan.push_back(row);
    endtask

    // Present one request, hold it until accepted, then record its expected result
    task automatic offer_request(input logic [drpm_pkg::ADDR_W-1:0] base,
                                 input logic [drpm_pkg::ADDR_W-1:0] len,
                                 input logic startup, input logic typed,
                                 input map_result_t typed_res, output map_result_t res);
        if (!steady) begin
            while ($urandom_range(99) < 12) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {len, base};
        s_tuser  <= startup;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        res = predict_mapping(base, len, startup);
        awaited_maps.push_back(typed ? typed_res : res);
    endtask

    // Drop valid and wait for every outstanding result
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaited_maps.size() != 0) @(posedge aclk);
    endtask

    // Draw one random request; the largest share reuse mapped spans so the scan finds runs
    task automatic draw_request(input bit late, output logic [drpm_pkg::ADDR_W-1:0] base,
                                output logic [drpm_pkg::ADDR_W-1:0] len,
                                output logic startup, output bit fresh);
        int    pick;
        int    off;
        span_t span;
        pick    = $urandom_range(99);
        startup = 1'($urandom_range(1));
        fresh   = 1'b0;
        if (!late && pick >= 30 && pick < 55 && shadow_used > 240 && mapped_spans.size() != 0)
            pick = 99;
        if (late && pick < 5) begin
            base = random_addr();
            len  = random_addr();
            if (len == '0) len = drpm_pkg::ADDR_W'(1);
        end else if (pick < 30) begin
            case ($urandom_range(2))
                0: begin
                    base = drpm_pkg::ADDR_W'($urandom_range(32'h7FFF_FFFF));
                    len  = drpm_pkg::ADDR_W'(1 + $urandom_range(32'h7FFF_FFFF - base[31:0]));
                end
                1: begin
                    startup = 1'b1;
                    base    = drpm_pkg::ADDR_W'($urandom_range(32'hBFFF_FFFF));
                    len     = drpm_pkg::ADDR_W'(1 + $urandom_range(32'hBFFF_FFFF
                                                                   - base[31:0]));
                end
                default: begin
                    base = drpm_pkg::ADDR_W'(32'hE000_0000 + $urandom_range(32'h1FFF_FFFF));
                    len  = drpm_pkg::ADDR_W'(1 + $urandom_range(32'hFFFF_FFFF - base[31:0]));
                end
            endcase
        end else if (pick < 40) begin
            base  = random_addr();
            len   = drpm_pkg::ADDR_W'(1 + $urandom_range(1 << 22));
            fresh = 1'b1;
        end else if (pick < 55 || mapped_spans.size() == 0) begin
            base  = random_addr();
            len   = drpm_pkg::ADDR_W'($urandom_range(1, 4 << PAGE_LOG2));
            fresh = 1'b1;
        end else begin
            span = mapped_spans[$urandom_range(mapped_spans.size() - 1)];
            if ($urandom_range(1)) begin
                base = span.base;
                len  = span.len;
            end else begin
                off  = int'($urandom_range(span.len[31:0] - 1));
                base = span.base + drpm_pkg::ADDR_W'(off);
                len  = drpm_pkg::ADDR_W'(1 + $urandom_range(span.len[31:0] - 1 - off));
            end
        end
    endtask

    // Collect results and compare against the oldest expectation
    always @(posedge aclk) begin : collect
        map_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_maps.size() == 0) begin
                note_mismatch("unrequested result", '0, m_tdata);
            end else begin
                want = awaited_maps.pop_front();
                if (m_tdata[drpm_pkg::ADDR_W-1:0] !== want.addr)
                    note_mismatch("mapped_addr", 64'(want.addr),
                                  64'(m_tdata[drpm_pkg::ADDR_W-1:0]));
                if (m_tdata[drpm_pkg::ADDR_W +: drpm_pkg::SLOTS_OUT_W] !== want.slots)
                    note_mismatch("slots_in_use", 64'(want.slots),
                                  64'(m_tdata[drpm_pkg::ADDR_W +: drpm_pkg::SLOTS_OUT_W]));
                if (m_tuser !== want.ok)
                    note_mismatch("ok", 64'(want.ok), 64'(m_tuser));
            end
        end
        m_tready <= steady || ($urandom_range(99) >= 12);
    end

    // End the run when nothing moves for too long
    initial begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stalled = 0;
            else
                stalled++;
        end
        $display("device_region_page_mapper_tb NOT OK");
        $finish;
    end

    initial begin : stimulus
        map_result_t                 res;
        logic [drpm_pkg::ADDR_W-1:0] base;
        logic [drpm_pkg::ADDR_W-1:0] len;
        logic                        startup;
        bit                          fresh;
        int                          closing_at;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;

        // Opening rows: pass-through edges first, while the table is empty
        add_row(52'h0,           52'h1,         1'b0, 1'b1, 52'h0,          1'b1, 9'd0);
        add_row(52'h7FFF_FFFF,   52'h1,         1'b0, 1'b1, 52'h7FFF_FFFF,  1'b1, 9'd0);
        add_row(52'h7FFF_FFFF,   52'h2,         1'b1, 1'b1, 52'h7FFF_FFFF,  1'b1, 9'd0);
        add_row(52'hBFFF_FFFF,   52'h1,         1'b1, 1'b1, 52'hBFFF_FFFF,  1'b1, 9'd0);
        add_row(52'hE000_0000,   52'h2000_0000, 1'b0, 1'b1, 52'hE000_0000,  1'b1, 9'd0);
        add_row(52'hFFFF_FFFF,   52'h1,         1'b1, 1'b1, 52'hFFFF_FFFF,  1'b1, 9'd0);
        // zero length just above the device area wraps its end to 4 GiB - 1
        add_row(52'h1_0000_0000, 52'h0,         1'b0, 1'b1, 52'h1_0000_0000, 1'b1, 9'd0);
        add_row(52'h7FFF_FFFF,   52'h2,         1'b0, 1'b0, '0, 1'b0, '0);
        add_row(52'hC000_0000,   52'h1,         1'b1, 1'b0, '0, 1'b0, '0);
        add_row(52'h9000_0000,   52'h0,         1'b0, 1'b0, '0, 1'b0, '0);
        add_row(52'h7FFF_FFFF,   52'h2,         1'b0, 1'b0, '0, 1'b0, '0);
        // top page, then a region whose last page needs 32 bits
        add_row(52'hF_FFFF_FFFF_FFFF, 52'h1,    1'b0, 1'b0, '0, 1'b0, '0);
        add_row(52'hF_FFFF_FFFF_FFFF, 52'h2,    1'b1, 1'b0, '0, 1'b0, '0);
        add_row(52'hF_FFFF_FFFF_FFFF, 52'h2,    1'b0, 1'b0, '0, 1'b0, '0);
        // mismatch skip and tail extension of a partial run
        add_row(52'h1_2340_0000, 52'h20_0000,   1'b0, 1'b0, '0, 1'b0, '0);
        add_row(52'h1_2320_0000, 52'h40_0000,   1'b0, 1'b0, '0, 1'b0, '0);
        add_row(52'h1_2340_0000, 52'h40_0000,   1'b1, 1'b0, '0, 1'b0, '0);
        add_row(52'h1_2350_1234, 52'h10,        1'b0, 1'b0, '0, 1'b0, '0);
        add_row(52'h8000_0000,   52'h20_0000,   1'b0, 1'b0, '0, 1'b0, '0);
        closing_at = plan.size();
        // Closing rows: overflow the table, then requests against a full table
        add_row(52'h0, 52'hF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 52'h0, 1'b0, 9'h100);
        add_row(52'hF_FFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 52'h0, 1'b0, 9'h100);
        add_row(52'h5_5555_5555_5555, 52'hA_AAAA_AAAA_AAAA, 1'b0, 1'b1, 52'h0, 1'b0, 9'h100);
        add_row(52'hE000_0000,   52'h2000_0001, 1'b0, 1'b1, 52'h0,          1'b0, 9'h100);
        add_row(52'hE000_0000,   52'h2000_0000, 1'b1, 1'b1, 52'hE000_0000,  1'b1, 9'h100);
        add_row(52'h1_2340_0000, 52'h20_0000,   1'b0, 1'b0, '0, 1'b0, '0);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < closing_at; i++)
            offer_request(plan[i].base, plan[i].len, plan[i].startup, plan[i].typed,
                          plan[i].want, res);

        // Random requests; late ones may overflow the table
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS - LATE_ITEMS) hold_until_drained();
            steady <= (k >= 300 && k < 450);
            draw_request(k >= RANDOM_ITEMS - LATE_ITEMS, base, len, startup, fresh);
            offer_request(base, len, startup, 1'b0, '0, res);
            if (fresh && res.ok) begin
                if (mapped_spans.size() >= SPAN_KEEP)
                    mapped_spans.delete($urandom_range(SPAN_KEEP - 1));
                mapped_spans.push_back({base, len});
            end
        end

        hold_until_drained();
        for (int i = closing_at; i < plan.size(); i++)
            offer_request(plan[i].base, plan[i].len, plan[i].startup, plan[i].typed,
                          plan[i].want, res);

        // Drain, then watch for stray results
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("device_region_page_mapper_tb OK");
        else
            $display("device_region_page_mapper_tb NOT OK");
        $finish;
    end

endmodule
